// File: design/tdsm_pkg.sv
// Package for the table-driven DFA string matcher.
// Holds command, register-index and scan-mode codes and the fixed field widths.
// No dependencies.
`default_nettype none

package tdsm_pkg;

    // Field widths fixed by the item format.
    localparam int STATE_W = 6;
    localparam int SYM_W   = 8;
    localparam int AUTO_IN_W = 2;
    localparam int MASK_W  = 64;
    localparam int CFG_IDX_W = 2;

    // Input word commands.
    localparam logic CMD_ENTRY = 1'b0;
    localparam logic CMD_TEXT  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASK    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AUTOMATON_SEL  = 2'd3;

    // Scan modes.
    localparam logic MODE_SUBSTRING = 1'b0;
    localparam logic MODE_PATTERN   = 1'b1;

endpackage

`default_nettype wire

// File: design/table_dfa_string_matcher_top.sv
// Top level of the table-driven DFA string matcher: transition RAM, scan pipeline,
// output register and configuration registers.
// Depends on tdsm_pkg.
//
//  channel  | ports                                  | dir | meaning
//  ---------+----------------------------------------+-----+-------------------------------
//  input    | s_valid s_ready s_cmd s_entry_* s_text_* | in  | table entry write or text byte
//  result   | m_valid m_ready m_found                | out | match flag at the last byte
//  config   | cfg_we cfg_index cfg_wdata             | in  | register write, no wait
//
// One word is accepted per cycle while the input is not stalled. A text byte reads the
// transition RAM at the edge it is accepted; the next cycle evaluates the hit and
// forwards the new state to the following byte's address, so bytes stream at one per
// cycle. The last byte's result passes from the lookup stage into the output register.
// Reset clears the scan state and registers; the RAM is not cleared. The input stalls
// only when a result is ready while the output register still holds an untaken word.
`default_nettype none

module table_dfa_string_matcher_top
    import tdsm_pkg::*;
#(
    parameter int NUM_AUTOMATA = 4,
    parameter int MAX_STATES   = 64,
    parameter int MAX_TEXT     = 4096
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_cmd,
    input  wire logic [AUTO_IN_W-1:0] s_entry_automaton,
    input  wire logic [STATE_W-1:0]   s_entry_state,
    input  wire logic [SYM_W-1:0]     s_entry_symbol,
    input  wire logic [STATE_W-1:0]   s_entry_next,
    input  wire logic [SYM_W-1:0]     s_text_byte,
    input  wire logic                 s_text_last,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_found,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MASK_W-1:0]    cfg_wdata
);

    localparam int AUTO_W = (NUM_AUTOMATA > 1) ? $clog2(NUM_AUTOMATA) : 1;
    localparam int ST_W   = $clog2(MAX_STATES);
    localparam int ADDR_W = AUTO_W + ST_W + SYM_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CNT_W  = $clog2(MAX_TEXT + 1);

    // Configuration registers.
    logic               scan_mode_reg;
    logic [STATE_W-1:0] pattern_length_reg;
    logic [MASK_W-1:0]  accept_mask_reg;
    logic [AUTO_IN_W-1:0] automaton_sel_reg;

    // Transition memory.
    logic [STATE_W-1:0] mem [DEPTH];
    logic [STATE_W-1:0] mem_q;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               rd_en;
    logic               wr_en;

    // Scan state.
    logic [CNT_W-1:0]   bytes_reg;
    logic [CNT_W-1:0]   bytes_next;
    logic [CNT_W-1:0]   bytes_after;
    logic [STATE_W-1:0] cur_reg;
    logic               hit_reg;

    // Lookup stage.
    logic               p_valid_reg;
    logic               p_last_reg;
    logic               p_tbl_reg;
    logic               p_test_reg;
    logic [STATE_W-1:0] p_st_in_reg;
    logic [CNT_W-1:0]   p_bytes_reg;

    // Output register.
    logic               m_valid_reg;
    logic               m_found_reg;

    logic               accept;
    logic               acc_text;
    logic               acc_entry;
    logic [STATE_W-1:0] start_state;
    logic [STATE_W-1:0] cur_state;
    logic [STATE_W-1:0] st_in;
    logic [STATE_W-1:0] st_new;
    logic               not_sat;
    logic               sel_ok;
    logic               st_ok;
    logic               entry_ok;
    logic               hit_now;
    logic               hit_total;
    logic               too_short;
    logic               found;
    logic               out_free;
    logic               stall;

    assign out_free = !m_valid_reg || m_ready;
    assign stall    = p_valid_reg && p_last_reg && !out_free;
    assign s_ready  = !stall;

    assign accept    = s_valid && s_ready;
    assign acc_text  = accept && (s_cmd == CMD_TEXT);
    assign acc_entry = accept && (s_cmd == CMD_ENTRY);

    assign start_state = (scan_mode_reg == MODE_PATTERN) ? STATE_W'(1) : '0;

    // The state left by the byte in the lookup stage is forwarded straight from the RAM, or kept if it read no entry.
    assign st_new    = p_tbl_reg ? mem_q : p_st_in_reg;
    assign cur_state = p_valid_reg ? st_new : cur_reg;
    assign st_in     = (bytes_reg == '0) ? start_state : cur_state;

    assign not_sat     = bytes_reg < CNT_W'(MAX_TEXT);
    assign bytes_after = not_sat ? bytes_reg + CNT_W'(1) : bytes_reg;
    assign sel_ok      = 32'(automaton_sel_reg) < NUM_AUTOMATA;
    assign st_ok       = 32'(st_in) < MAX_STATES;
    assign entry_ok    = (32'(s_entry_automaton) < NUM_AUTOMATA)
                      && (32'(s_entry_state) < MAX_STATES);

    assign rd_en   = acc_text && not_sat && sel_ok && st_ok;
    assign wr_en   = acc_entry && entry_ok;
    assign rd_addr = {AUTO_W'(automaton_sel_reg), ST_W'(st_in), s_text_byte};
    assign wr_addr = {AUTO_W'(s_entry_automaton), ST_W'(s_entry_state), s_entry_symbol};

    always_comb begin
        if (!acc_text) begin
            bytes_next = bytes_reg;
        end else if (s_text_last) begin
            bytes_next = '0;
        end else begin
            bytes_next = bytes_after;
        end
    end

    always_comb begin
        if (scan_mode_reg == MODE_PATTERN) begin
            hit_now = p_test_reg && accept_mask_reg[st_new];
        end else begin
            hit_now = p_test_reg && (pattern_length_reg != '0)
                   && (st_new == pattern_length_reg);
        end
    end

    assign hit_total = hit_reg || hit_now;
    assign too_short = (scan_mode_reg == MODE_SUBSTRING)
                    && ((pattern_length_reg == '0)
                        || (CNT_W'(pattern_length_reg) > p_bytes_reg));
    assign found     = hit_total && !too_short;

    // Transition RAM: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_entry_next;
        end
        if (rd_en) begin
            mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_mode_reg      <= MODE_SUBSTRING;
            pattern_length_reg <= '0;
            accept_mask_reg    <= '0;
            automaton_sel_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SCAN_MODE:      scan_mode_reg      <= cfg_wdata[0];
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[STATE_W-1:0];
                REG_ACCEPT_MASK:    accept_mask_reg    <= cfg_wdata;
                REG_AUTOMATON_SEL:  automaton_sel_reg  <= cfg_wdata[AUTO_IN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg   <= '0;
            cur_reg     <= '0;
            hit_reg     <= 1'b0;
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            p_tbl_reg   <= 1'b0;
            p_test_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            bytes_reg <= bytes_next;
            if (!stall) begin
                p_valid_reg <= acc_text;
                p_last_reg  <= s_text_last;
                p_tbl_reg   <= rd_en;
                p_test_reg  <= not_sat && sel_ok;
                if (p_valid_reg) begin
                    cur_reg <= st_new;
                    hit_reg <= p_last_reg ? 1'b0 : hit_total;
                end
            end
            if (out_free) begin
                m_valid_reg <= p_valid_reg && p_last_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (!stall) begin
            p_st_in_reg <= st_in;
            p_bytes_reg <= bytes_after;
        end
        if (out_free) begin
            m_found_reg <= found;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_found = m_found_reg;

    a_result_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(p_valid_reg && p_last_reg))
        else $error("result word without a last byte in the lookup stage");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_reg <= CNT_W'(MAX_TEXT))
        else $error("byte counter passed its saturation point");

    a_last_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_text && s_text_last) |=> (bytes_reg == '0) && p_valid_reg && p_last_reg)
        else $error("last byte did not restart the text");

    a_read_feeds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> p_valid_reg && p_tbl_reg && p_test_reg)
        else $error("table read not consumed by the lookup stage");

endmodule

`default_nettype wire

// File: test/table_dfa_string_matcher_top_tb.sv
// Self-checking testbench for table_dfa_string_matcher_top: directed table, then random texts.
// Expected match flags come from the plan rows, else a scan model of the loaded transition tables.
// Depends on tdsm_pkg and the design top level.
`timescale 1ns / 100ps

module table_dfa_string_matcher_top_tb;
    import tdsm_pkg::*;

    localparam int N_AUTO      = 4;
    localparam int N_STATES    = 64;
    localparam int TEXT_MAX    = 4096;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 14;
    localparam int PHASE_WORDS = 130;
    localparam int CHOKE_PHASE = 5;
    localparam int LONG_PHASE  = 9;
    localparam int LONG_LEN    = 100;
    localparam int PLAN_ROWS   = 26;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic                 cmd;
        logic [AUTO_IN_W-1:0] automaton;
        logic [STATE_W-1:0]   state;
        logic [SYM_W-1:0]     symbol;
        logic [STATE_W-1:0]   nxt;
        logic [SYM_W-1:0]     text_byte;
        logic                 last;
    } word_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [MASK_W-1:0]    reg_val;
        word_t                w;
        logic                 checked;
        logic                 want;
    } plan_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_style_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_cmd = CMD_ENTRY;
    logic [AUTO_IN_W-1:0] s_entry_automaton = '0;
    logic [STATE_W-1:0]   s_entry_state = '0;
    logic [SYM_W-1:0]     s_entry_symbol = '0;
    logic [STATE_W-1:0]   s_entry_next = '0;
    logic [SYM_W-1:0]     s_text_byte = '0;
    logic                 s_text_last = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_found;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SCAN_MODE;
    logic [MASK_W-1:0]    cfg_wdata = '0;

    // Local copy of the registers and scan state.
    logic                 cfg_mode = MODE_SUBSTRING;
    logic [STATE_W-1:0]   cfg_plen = '0;
    logic [MASK_W-1:0]    cfg_mask = '0;
    logic [AUTO_IN_W-1:0] cfg_sel = '0;
    logic [STATE_W-1:0]   scan_state = '0;
    logic                 hit_seen = 1'b0;
    int                   text_count = 0;
    logic [STATE_W-1:0]   dfa_next [N_AUTO*N_STATES*256];
    bit                   entry_written [N_AUTO*N_STATES*256];

    logic                 found_expected [$];
    int                   errors = 0;
    int                   words_sent = 0;
    int                   burst_left = 0;
    int                   idle_cycles = 0;
    logic                 start_choke = 1'b0;
    logic [SYM_W-1:0]     alphabet [4];

    int                   hold_left = 0;
    logic                 choke_done = 1'b0;
    int                   seg_left = 0;
    rx_style_t            seg_style = RX_OPEN;

    plan_row_t plan [PLAN_ROWS] = '{
        // With the reset settings a zero pattern length never matches.
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_ENTRY, 2'd0, 6'd0, 8'h00, 6'd1, 8'h00, 1'b0}, 1'b0, 1'b0},
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_ENTRY, 2'd0, 6'd1, 8'hff, 6'd2, 8'h00, 1'b0}, 1'b0, 1'b0},
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_TEXT, 2'd0, 6'd0, 8'h00, 6'd0, 8'h00, 1'b1}, 1'b1, 1'b0},
        '{ROW_REG, REG_PATTERN_LENGTH, 64'd2, '0, 1'b0, 1'b0},
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_TEXT, 2'd0, 6'd0, 8'h00, 6'd0, 8'h00, 1'b0}, 1'b0, 1'b0},
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_TEXT, 2'd0, 6'd0, 8'h00, 6'd0, 8'hff, 1'b1}, 1'b1, 1'b1},
        // One byte cannot hold a two-byte pattern.
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_TEXT, 2'd0, 6'd0, 8'h00, 6'd0, 8'h00, 1'b1}, 1'b1, 1'b0},
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_ENTRY, 2'd3, 6'd63, 8'hff, 6'd63, 8'h00, 1'b0}, 1'b0, 1'b0},
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_ENTRY, 2'd3, 6'd1, 8'hff, 6'd63, 8'h00, 1'b0}, 1'b0, 1'b0},
        '{ROW_REG, REG_SCAN_MODE, 64'd1, '0, 1'b0, 1'b0},
        '{ROW_REG, REG_AUTOMATON_SEL, 64'd3, '0, 1'b0, 1'b0},
        '{ROW_REG, REG_ACCEPT_MASK, 64'h8000_0000_0000_0000, '0, 1'b0, 1'b0},
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_TEXT, 2'd0, 6'd0, 8'h00, 6'd0, 8'hff, 1'b0}, 1'b0, 1'b0},
        // Table write in the middle of a text, read by the very next byte.
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_ENTRY, 2'd3, 6'd63, 8'h00, 6'd1, 8'h00, 1'b0}, 1'b0, 1'b0},
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_TEXT, 2'd0, 6'd0, 8'h00, 6'd0, 8'h00, 1'b1}, 1'b1, 1'b1},
        '{ROW_REG, REG_ACCEPT_MASK, 64'd0, '0, 1'b0, 1'b0},
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_TEXT, 2'd0, 6'd0, 8'h00, 6'd0, 8'hff, 1'b1}, 1'b1, 1'b0},
        '{ROW_REG, REG_ACCEPT_MASK, '1, '0, 1'b0, 1'b0},
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_TEXT, 2'd0, 6'd0, 8'h00, 6'd0, 8'hff, 1'b0}, 1'b0, 1'b0},
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_TEXT, 2'd0, 6'd0, 8'h00, 6'd0, 8'hff, 1'b1}, 1'b1, 1'b1},
        '{ROW_REG, REG_PATTERN_LENGTH, 64'd63, '0, 1'b0, 1'b0},
        '{ROW_REG, REG_SCAN_MODE, 64'd0, '0, 1'b0, 1'b0},
        '{ROW_REG, REG_AUTOMATON_SEL, 64'd0, '0, 1'b0, 1'b0},
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_TEXT, 2'd0, 6'd0, 8'h00, 6'd0, 8'h00, 1'b1}, 1'b1, 1'b0},
        '{ROW_REG, REG_PATTERN_LENGTH, 64'd1, '0, 1'b0, 1'b0},
        '{ROW_WORD, REG_SCAN_MODE, '0,
          '{CMD_TEXT, 2'd0, 6'd0, 8'h00, 6'd0, 8'h00, 1'b1}, 1'b1, 1'b1}
    };

    table_dfa_string_matcher_top #(
        .NUM_AUTOMATA(N_AUTO),
        .MAX_STATES  (N_STATES),
        .MAX_TEXT    (TEXT_MAX)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_entry_automaton(s_entry_automaton),
        .s_entry_state    (s_entry_state),
        .s_entry_symbol   (s_entry_symbol),
        .s_entry_next     (s_entry_next),
        .s_text_byte      (s_text_byte),
        .s_text_last      (s_text_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [STATE_W-1:0] start_state();
        return (cfg_mode == MODE_PATTERN) ? 6'd1 : 6'd0;
    endfunction

    // Steps the scan model by one accepted word and tells whether it ends a text.
    function automatic void scan_word(input word_t w, output logic emits, output logic found);
        logic [STATE_W-1:0] st;
        logic [15:0]        at;
        emits = 1'b0;
        found = 1'b0;
        if (w.cmd == CMD_ENTRY) begin
            at = {w.automaton, w.state, w.symbol};
            dfa_next[at] = w.nxt;
            entry_written[at] = 1'b1;
            return;
        end
        st = (text_count == 0) ? start_state() : scan_state;
        // Past the length limit the byte only counts for its last mark.
        if (text_count < TEXT_MAX) begin
            text_count++;
            st = dfa_next[{cfg_sel, st, w.text_byte}];
            if (cfg_mode == MODE_SUBSTRING) begin
                if (cfg_plen != 0 && st == cfg_plen) hit_seen = 1'b1;
            end else if (cfg_mask[st]) begin
                hit_seen = 1'b1;
            end
            scan_state = st;
        end
        if (w.last) begin
            emits = 1'b1;
            found = hit_seen && !(cfg_mode == MODE_SUBSTRING &&
                                  (cfg_plen == 0 || cfg_plen > text_count));
            hit_seen = 1'b0;
            text_count = 0;
        end
    endfunction

    // Mostly walks forward so that match states are reached, sometimes falls back.
    function automatic logic [STATE_W-1:0] pick_next(input logic [STATE_W-1:0] from);
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return from + 6'd1;
        if (r < 17) return 6'($urandom_range(0, from));
        return 6'($urandom_range(0, N_STATES - 1));
    endfunction

    task automatic send_word(input word_t w, input logic pinned = 1'b0,
                             input logic pinned_found = 1'b0);
        logic emits;
        logic found;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
        end
        burst_left--;
        s_valid           <= 1'b1;
        s_cmd             <= w.cmd;
        s_entry_automaton <= w.automaton;
        s_entry_state     <= w.state;
        s_entry_symbol    <= w.symbol;
        s_entry_next      <= w.nxt;
        s_text_byte       <= w.text_byte;
        s_text_last       <= w.last;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        scan_word(w, emits, found);
        if (emits) found_expected.push_back(pinned ? pinned_found : found);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (found_expected.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_SCAN_MODE:      cfg_mode = val[0];
            REG_PATTERN_LENGTH: cfg_plen = val[STATE_W-1:0];
            REG_ACCEPT_MASK:    cfg_mask = val;
            REG_AUTOMATON_SEL:  cfg_sel  = val[AUTO_IN_W-1:0];
            default: ;
        endcase
    endtask

    // Sends one text; any table entry a byte is about to read gets loaded first.
    task automatic send_text(input int len);
        word_t       w;
        word_t       fill;
        logic [15:0] at;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                w = word_t'($urandom);
                w.cmd = CMD_ENTRY;
                send_word(w);
            end
            w = word_t'($urandom);
            w.cmd = CMD_TEXT;
            if ($urandom_range(0, 6) != 0) w.text_byte = alphabet[$urandom_range(0, 3)];
            w.last = (k == len - 1);
            at = {cfg_sel, (text_count == 0) ? start_state() : scan_state, w.text_byte};
            if (text_count < TEXT_MAX && !entry_written[at]) begin
                fill = word_t'($urandom);
                fill.cmd = CMD_ENTRY;
                {fill.automaton, fill.state, fill.symbol} = at;
                fill.nxt = pick_next(at[13:8]);
                send_word(fill);
            end
            send_word(w);
        end
    endtask

    // Receiver: segments of different stall styles, plus one long hold on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (start_choke && !choke_done) begin
            m_ready    <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            choke_done <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_left  <= $urandom_range(1, 64);
                seg_style <= rx_style_t'($urandom_range(0, 3));
            end else begin
                seg_left <= seg_left - 1;
            end
            case (seg_style)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= !m_ready;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (found_expected.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result word with none expected, actual found %0b",
                             $time, m_found);
            end else if (m_found !== found_expected[0]) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, found_expected[0], m_found);
                void'(found_expected.pop_front());
            end else begin
                void'(found_expected.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("table_dfa_string_matcher_top_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic               mode;
        logic [STATE_W-1:0] plen;
        logic [MASK_W-1:0]  mask;
        logic [MASK_W-1:0]  noise;
        int                 phase_start;
        int                 len;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
                cfg_we <= 1'b0;
            end else begin
                send_word(plan[i].w, plan[i].checked, plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            mode = 1'($urandom_range(0, 1));
            case (ph)
                0:          plen = 6'd0;
                1:          plen = 6'd63;
                default:    plen = 6'($urandom_range(1, 5));
            endcase
            case (ph)
                2:       mask = '0;
                3:       mask = '1;
                default: mask = {$urandom, $urandom} & {$urandom, $urandom};
            endcase
            if (ph == LONG_PHASE) begin
                mode = MODE_SUBSTRING;
                plen = 6'd63;
            end
            noise = {$urandom, $urandom};
            // Registers change only with nothing in flight and between texts.
            drain();
            write_reg(REG_SCAN_MODE, {noise[MASK_W-1:1], mode});
            write_reg(REG_PATTERN_LENGTH, {noise[MASK_W-1:STATE_W], plen});
            write_reg(REG_ACCEPT_MASK, mask);
            write_reg(REG_AUTOMATON_SEL, {noise[MASK_W-1:AUTO_IN_W], 2'(ph % N_AUTO)});
            cfg_we <= 1'b0;
            foreach (alphabet[i]) alphabet[i] = 8'($urandom);
            if (ph == CHOKE_PHASE) start_choke <= 1'b1;

            if (ph == LONG_PHASE) begin
                send_text(LONG_LEN);
            end else begin
                phase_start = words_sent;
                while (words_sent - phase_start < PHASE_WORDS) begin
                    // Short texts during the long hold pile up results and back up the input.
                    if (ph == CHOKE_PHASE) len = $urandom_range(1, 2);
                    else if ($urandom_range(0, 7) == 0) len = $urandom_range(13, 40);
                    else len = $urandom_range(1, 12);
                    send_text(len);
                end
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (errors == 0) begin
            $display("table_dfa_string_matcher_top_tb passed");
        end else begin
            $display("table_dfa_string_matcher_top_tb failed");
        end
        $finish;
    end

endmodule

// File: sim.f
design/tdsm_pkg.sv
design/table_dfa_string_matcher_top.sv
test/table_dfa_string_matcher_top_tb.sv
